// ===== design/lls_pkg.sv =====
// Package for the line lap supervisor: payload structs, codes, register map
// and register reset values. No dependencies.
package lls_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DistW = 31;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_RUN   = 3'd2,
    PH_ARMED = 3'd3,
    PH_ADV   = 3'd4
  } lap_phase_e;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_ABANDON = 2'd1,
    KIND_UPDATE  = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    TC_ON_LINE = 2'd0,
    TC_CROSS   = 2'd1,
    TC_LOST    = 2'd2
  } track_class_e;

  typedef enum logic [1:0] {
    WHY_NONE    = 2'd0,
    WHY_TIMEOUT = 2'd1,
    WHY_LOST    = 2'd2,
    WHY_DONE    = 2'd3
  } stop_reason_e;

  typedef enum logic [2:0] {
    REG_MAX_RUN       = 3'd0,
    REG_LOST_STOP     = 3'd1,
    REG_LEAVE_CONFIRM = 3'd2,
    REG_ARM_DISTANCE  = 3'd3,
    REG_FINISH_CONF   = 3'd4,
    REG_FINISH_ADV    = 3'd5
  } reg_index_e;

  localparam logic [TimeW-1:0] MaxRunReset       = 32'd60000;
  localparam logic [TimeW-1:0] LostStopReset     = 32'd500;
  localparam logic [TimeW-1:0] LeaveConfirmReset = 32'd200;
  localparam logic [DistW-1:0] ArmDistanceReset  = 31'd10000;
  localparam logic [TimeW-1:0] FinishConfReset   = 32'd50;
  localparam logic [DistW-1:0] FinishAdvReset    = 31'd0;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TimeW-1:0] now_ms;
    logic [1:0]       track_class;
    logic [DistW-1:0] distance_counts;
  } in_item_t;

  typedef struct packed {
    logic [2:0] lap_state;
    logic       stopped;
    logic [1:0] stop_reason;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0] max_run_ms;
    logic [TimeW-1:0] lost_stop_ms;
    logic [TimeW-1:0] leave_confirm_ms;
    logic [DistW-1:0] arm_distance_counts;
    logic [TimeW-1:0] finish_confirm_ms;
    logic [DistW-1:0] finish_advance_counts;
  } cfg_t;

endpackage

// ===== design/lls_cfg_regs.sv =====
// Configuration register file of the line lap supervisor behind an APB-style port.
// Depends on lls_pkg.
module lls_cfg_regs import lls_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MAX_RUN:       cfg_d.max_run_ms            = pwdata;
        REG_LOST_STOP:     cfg_d.lost_stop_ms          = pwdata;
        REG_LEAVE_CONFIRM: cfg_d.leave_confirm_ms      = pwdata;
        REG_ARM_DISTANCE:  cfg_d.arm_distance_counts   = pwdata[DistW-1:0];
        REG_FINISH_CONF:   cfg_d.finish_confirm_ms     = pwdata;
        REG_FINISH_ADV:    cfg_d.finish_advance_counts = pwdata[DistW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_RUN:       prdata = cfg_q.max_run_ms;
      REG_LOST_STOP:     prdata = cfg_q.lost_stop_ms;
      REG_LEAVE_CONFIRM: prdata = cfg_q.leave_confirm_ms;
      REG_ARM_DISTANCE:  prdata = {1'b0, cfg_q.arm_distance_counts};
      REG_FINISH_CONF:   prdata = cfg_q.finish_confirm_ms;
      REG_FINISH_ADV:    prdata = {1'b0, cfg_q.finish_advance_counts};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_run_ms            <= MaxRunReset;
      cfg_q.lost_stop_ms          <= LostStopReset;
      cfg_q.leave_confirm_ms      <= LeaveConfirmReset;
      cfg_q.arm_distance_counts   <= ArmDistanceReset;
      cfg_q.finish_confirm_ms     <= FinishConfReset;
      cfg_q.finish_advance_counts <= FinishAdvReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/lls_lap_core.sv =====
// Lap state machine and timers of the line lap supervisor; computes one result
// per stepped transaction. Depends on lls_pkg.
module lls_lap_core import lls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_en_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  lap_phase_e       phase_q, phase_d;
  logic [TimeW-1:0] run_start_q, run_start_d;
  logic [TimeW-1:0] since_q, since_d;
  logic [TimeW-1:0] lost_since_q, lost_since_d;
  logic             lost_act_q, lost_act_d;
  logic [DistW-1:0] trig_q, trig_d;
  stop_reason_e     why;

  logic [TimeW-1:0] run_el, since_el, lost_el;
  logic [DistW-1:0] adv_el;
  logic             is_lost, is_cross;

  assign run_el   = item_i.now_ms - run_start_q;
  assign since_el = item_i.now_ms - since_q;
  assign lost_el  = item_i.now_ms - lost_since_q;
  assign adv_el   = item_i.distance_counts - trig_q;
  assign is_lost  = (item_i.track_class == TC_LOST);
  assign is_cross = (item_i.track_class == TC_CROSS);

  always_comb begin
    phase_d      = phase_q;
    run_start_d  = run_start_q;
    since_d      = since_q;
    lost_since_d = lost_since_q;
    lost_act_d   = lost_act_q;
    trig_d       = trig_q;
    why          = WHY_NONE;
    case (item_i.kind)
      KIND_START: begin
        phase_d      = PH_WAIT;
        run_start_d  = item_i.now_ms;
        since_d      = item_i.now_ms;
        lost_since_d = '0;
        lost_act_d   = 1'b0;
        trig_d       = '0;
      end
      KIND_ABANDON: begin
        phase_d = PH_IDLE;
      end
      KIND_UPDATE: begin
        if (phase_q != PH_IDLE) begin
          if (run_el >= cfg_i.max_run_ms) begin
            why = WHY_TIMEOUT;
          end else begin
            if (is_lost) begin
              if (!lost_act_q) begin
                lost_act_d   = 1'b1;
                lost_since_d = item_i.now_ms;
              end else if (lost_el >= cfg_i.lost_stop_ms) begin
                why = WHY_LOST;
              end
            end else begin
              lost_act_d   = 1'b0;
              lost_since_d = '0;
            end
            if (why == WHY_NONE) begin
              case (phase_q)
                PH_WAIT: begin
                  if (!is_cross) begin
                    if (since_el >= cfg_i.leave_confirm_ms) begin
                      phase_d = PH_RUN;
                      since_d = item_i.now_ms;
                    end
                  end else begin
                    since_d = item_i.now_ms;
                  end
                end
                PH_RUN: begin
                  if (item_i.distance_counts >= cfg_i.arm_distance_counts) begin
                    phase_d = PH_ARMED;
                    since_d = item_i.now_ms;
                  end
                end
                PH_ARMED: begin
                  if (is_cross) begin
                    if (since_el >= cfg_i.finish_confirm_ms) begin
                      if (cfg_i.finish_advance_counts == '0) begin
                        why = WHY_DONE;
                      end else begin
                        trig_d  = item_i.distance_counts;
                        phase_d = PH_ADV;
                        since_d = item_i.now_ms;
                      end
                    end
                  end else begin
                    since_d = item_i.now_ms;
                  end
                end
                PH_ADV: begin
                  if (item_i.distance_counts >= trig_q &&
                      adv_el >= cfg_i.finish_advance_counts) begin
                    why = WHY_DONE;
                  end
                end
                default: begin
                  why = WHY_NONE;
                end
              endcase
            end
          end
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
    if (phase_d == PH_IDLE || why != WHY_NONE) begin
      phase_d      = PH_IDLE;
      run_start_d  = '0;
      since_d      = '0;
      lost_since_d = '0;
      lost_act_d   = 1'b0;
      trig_d       = '0;
    end
  end

  assign result_o.lap_state   = phase_d;
  assign result_o.stopped     = (why != WHY_NONE);
  assign result_o.stop_reason = why;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      run_start_q  <= '0;
      since_q      <= '0;
      lost_since_q <= '0;
      lost_act_q   <= 1'b0;
      trig_q       <= '0;
    end else if (step_en_i) begin
      phase_q      <= phase_d;
      run_start_q  <= run_start_d;
      since_q      <= since_d;
      lost_since_q <= lost_since_d;
      lost_act_q   <= lost_act_d;
      trig_q       <= trig_d;
    end
  end

`ifndef SYNTHESIS
  a_stop_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && result_o.stopped |=> phase_q == PH_IDLE)
    else $error("A stopping transaction did not return the lap to idle.");

  a_idle_is_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> run_start_q == '0 && since_q == '0 && !lost_act_q)
    else $error("Lap state not cleared while idle.");

  a_lost_inactive_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lost_act_q |-> lost_since_q == '0)
    else $error("Lost interval start kept without an open lost interval.");

  a_trigger_only_in_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_ADV |-> trig_q == '0)
    else $error("Finish trigger distance held outside the finish advance phase.");
`endif

endmodule

// ===== design/line_lap_supervisor.sv =====
// Top level of the line lap supervisor: input register, lap core, result
// register and configuration port. Depends on lls_pkg, lls_cfg_regs, lls_lap_core.

// The supervisor takes one transaction per clock cycle while in_ready_o is
// high and returns exactly one result per transaction: the item is held in the
// input register until the result register is free, then the lap logic
// evaluates it against the stored lap state and writes the state and the
// result register at the same edge, so each item sees the state left by the
// one before it. Both sides are decoupled by these registers, so a stalled
// result only stops intake once both stages are full. The user must write the
// configuration registers over the APB port only while no transaction is in
// flight; the block itself does not enforce this. They read back at any time.
module line_lap_supervisor import lls_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_vld_q;
  out_item_t res_q, res;
  logic      res_vld_q;
  logic      advance;

  assign advance    = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || advance;

  lls_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lls_lap_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_item_o  = res_q;

endmodule
